/* hdl/gtb_pkg.sv */
package gtb_pkg;

   localparam int TEXT_CAPACITY = 4096;
   localparam int MAX_LINES     = 1024;
   localparam int TEXT_AW       = $clog2(TEXT_CAPACITY);
   localparam int LINE_AW       = $clog2(MAX_LINES);
   localparam int POS_W         = 13;
   localparam int CNT_W         = 11;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   // command kinds
   localparam logic [3:0] KIND_INSERT   = 4'd0;
   localparam logic [3:0] KIND_DEL_PREV = 4'd1;
   localparam logic [3:0] KIND_DEL_NEXT = 4'd2;
   localparam logic [3:0] KIND_LEFT     = 4'd3;
   localparam logic [3:0] KIND_RIGHT    = 4'd4;
   localparam logic [3:0] KIND_MOVE_TO  = 4'd5;
   localparam logic [3:0] KIND_DEL_RNG  = 4'd6;
   localparam logic [3:0] KIND_READ     = 4'd7;
   localparam logic [3:0] KIND_LINE_COL = 4'd8;
   localparam logic [3:0] KIND_LINE_OFF = 4'd9;

   // result status codes
   localparam logic [1:0] ST_DONE       = 2'd0;
   localparam logic [1:0] ST_NOP        = 2'd1;
   localparam logic [1:0] ST_TEXT_FULL  = 2'd2;
   localparam logic [1:0] ST_LINES_FULL = 2'd3;

   typedef struct packed {
      logic               en;
      logic [TEXT_AW-1:0] addr;
      logic [7:0]         data;
   } text_wr_type;

   typedef struct packed {
      logic               en;
      logic [LINE_AW-1:0] addr;
      logic [POS_W-1:0]   data;
   } line_wr_type;

endpackage

/* hdl/gap_text_buffer_line_index.sv */
// Gap-buffer text store with a sorted line-start table.
// req channel: one command item per handshake; req_tuser carries the kind,
// req_tdata the operands. rsp channel: exactly one result item per command.
// Text bytes live in a 4096 x 8 RAM, line starts in a 1024 x 13 RAM, both
// with registered reads; a sequencer walks them.
// Work per command: rejected or no-op commands go straight to the result;
// read and line offset make one RAM read; line/column runs a binary search
// over the line table; cursor moves carry bytes across the gap one at a time;
// insert shifts every line start after the cursor; single deletes compact
// the whole line table; range delete compacts the table, then moves the gap.
// One command is in flight at a time; req_tready is high only when idle,
// so the next command is taken once the previous result is registered.
// Reset empties the text (all gap), leaves one line starting at offset 0,
// and drops any pending result; no clearing pass is needed.
// If the receiver stalls, one more command is taken and its finished result
// holds the sequencer until the waiting one is taken.
module gap_text_buffer_line_index (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [3:0]  req_tuser,  // kind
   input  logic [47:0] req_tdata,  // value, position, position_end, line_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, byte_read, line_number, column, line_offset, text_length,
   // cursor, lines_total
   output logic [87:0] rsp_tdata
);

   localparam int PW = gtb_pkg::POS_W;
   localparam int CW = gtb_pkg::CNT_W;
   localparam int TA = gtb_pkg::TEXT_AW;
   localparam int LA = gtb_pkg::LINE_AW;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR,
      S_MOVE, S_MV_LWR, S_MV_RWR, S_RD_WAIT, S_BS_RD, S_BS_CMP,
      S_OFF_WAIT, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [3:0]    kind_ff, kind_in;
   logic [7:0]    value_ff, value_in;
   logic [PW-1:0] pos_ff, pos_in, pend_ff, pend_in;
   logic [LA-1:0] lidx_ff, lidx_in;
   logic [PW-1:0] gl_ff, gl_in, gh_ff, gh_in;
   logic [CW-1:0] lines_ff, lines_in, idx_ff, idx_in, wr_ff, wr_in;
   logic [PW-1:0] from_ff, from_in, to_ff, to_in, target_ff, target_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [LA-1:0] mid_ff, mid_in, best_ff, best_in;
   logic [PW-1:0] bval_ff, bval_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    rd_ff, rd_in;
   logic [LA-1:0] lnum_ff, lnum_in;
   logic [PW-1:0] col_ff, col_in, loff_ff, loff_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [87:0]   rsp_data_ff, rsp_data_in;
   logic          lzero_ff, lzero_in;

   gtb_pkg::text_wr_type text_wr;
   gtb_pkg::line_wr_type line_wr;
   logic [TA-1:0] text_raddr;
   logic [LA-1:0] line_raddr;
   logic [7:0]    text_q;
   logic [PW-1:0] line_raw, line_q;

   logic [PW-1:0] len, clamp_pos, clamp_pend, del, rd_pos;
   logic          is_nl;
   logic [CW:0]   mid_sum;

   gtb_text_ram u_text (
      .clock  (clock),
      .wr     (text_wr),
      .rd_addr(text_raddr),
      .rd_data(text_q)
   );

   gtb_line_ram u_line (
      .clock  (clock),
      .wr     (line_wr),
      .rd_addr(line_raddr),
      .rd_data(line_raw)
   );

   // entry zero of the line table always reads as offset 0
   assign line_q = lzero_ff ? '0 : line_raw;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign len        = PW'(gtb_pkg::TEXT_CAPACITY) - (gh_ff - gl_ff);
   assign clamp_pos  = (pos_ff > len) ? len : pos_ff;
   assign clamp_pend = (pend_ff > len) ? len : pend_ff;
   assign del        = to_ff - from_ff;
   assign is_nl      = (value_ff == gtb_pkg::NEWLINE_BYTE);
   assign rd_pos     = (pos_ff < gl_ff) ? pos_ff : pos_ff + (gh_ff - gl_ff);
   assign mid_sum    = (CW+1)'(lo_ff) + (CW+1)'(hi_ff) - 1'b1;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      pend_in      = pend_ff;
      lidx_in      = lidx_ff;
      gl_in        = gl_ff;
      gh_in        = gh_ff;
      lines_in     = lines_ff;
      idx_in       = idx_ff;
      wr_in        = wr_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      target_in    = target_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      best_in      = best_ff;
      bval_in      = bval_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      lnum_in      = lnum_ff;
      col_in       = col_ff;
      loff_in      = loff_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      text_wr      = '0;
      line_wr      = '0;
      text_raddr   = '0;
      line_raddr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               value_in  = req_tdata[7:0];
               pos_in    = req_tdata[20:8];
               pend_in   = req_tdata[33:21];
               lidx_in   = req_tdata[43:34];
               status_in = gtb_pkg::ST_DONE;
               rd_in     = '0;
               lnum_in   = '0;
               col_in    = '0;
               loff_in   = '0;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (kind_ff)
               gtb_pkg::KIND_INSERT: begin
                  if (gl_ff == gh_ff) begin
                     status_in = gtb_pkg::ST_TEXT_FULL;
                  end else if (is_nl && lines_ff >= CW'(gtb_pkg::MAX_LINES)) begin
                     status_in = gtb_pkg::ST_LINES_FULL;
                  end else begin
                     text_wr.en   = 1'b1;
                     text_wr.addr = gl_ff[TA-1:0];
                     text_wr.data = value_ff;
                     from_in      = gl_ff;
                     gl_in        = gl_ff + 1'b1;
                     idx_in       = lines_ff - 1'b1;
                     state_in     = S_INS_RD;
                  end
               end
               gtb_pkg::KIND_DEL_PREV: begin
                  if (gl_ff == '0) begin
                     status_in = gtb_pkg::ST_NOP;
                  end else begin
                     from_in  = gl_ff - 1'b1;
                     to_in    = gl_ff;
                     gl_in    = gl_ff - 1'b1;
                     idx_in   = '0;
                     wr_in    = '0;
                     state_in = S_DEL_RD;
                  end
               end
               gtb_pkg::KIND_DEL_NEXT: begin
                  if (gh_ff >= PW'(gtb_pkg::TEXT_CAPACITY)) begin
                     status_in = gtb_pkg::ST_NOP;
                  end else begin
                     from_in  = gl_ff;
                     to_in    = gl_ff + 1'b1;
                     gh_in    = gh_ff + 1'b1;
                     idx_in   = '0;
                     wr_in    = '0;
                     state_in = S_DEL_RD;
                  end
               end
               gtb_pkg::KIND_LEFT: begin
                  if (gl_ff == '0) begin
                     status_in = gtb_pkg::ST_NOP;
                  end else begin
                     target_in = gl_ff - 1'b1;
                     state_in  = S_MOVE;
                  end
               end
               gtb_pkg::KIND_RIGHT: begin
                  if (gh_ff >= PW'(gtb_pkg::TEXT_CAPACITY)) begin
                     status_in = gtb_pkg::ST_NOP;
                  end else begin
                     target_in = gl_ff + 1'b1;
                     state_in  = S_MOVE;
                  end
               end
               gtb_pkg::KIND_MOVE_TO: begin
                  target_in = clamp_pos;
                  state_in  = S_MOVE;
               end
               gtb_pkg::KIND_DEL_RNG: begin
                  if (clamp_pos >= clamp_pend) begin
                     status_in = gtb_pkg::ST_NOP;
                  end else begin
                     from_in   = clamp_pos;
                     to_in     = clamp_pend;
                     target_in = clamp_pos;
                     idx_in    = '0;
                     wr_in     = '0;
                     state_in  = S_DEL_RD;
                  end
               end
               gtb_pkg::KIND_READ: begin
                  if (pos_ff >= len) begin
                     status_in = gtb_pkg::ST_NOP;
                  end else begin
                     text_raddr = rd_pos[TA-1:0];
                     state_in   = S_RD_WAIT;
                  end
               end
               gtb_pkg::KIND_LINE_COL: begin
                  lo_in    = '0;
                  hi_in    = lines_ff;
                  best_in  = '0;
                  bval_in  = '0;
                  state_in = S_BS_RD;
               end
               gtb_pkg::KIND_LINE_OFF: begin
                  lnum_in    = (CW'(lidx_ff) >= lines_ff) ? LA'(lines_ff - 1'b1) : lidx_ff;
                  line_raddr = lnum_in;
                  state_in   = S_OFF_WAIT;
               end
               default: begin
                  status_in = gtb_pkg::ST_NOP;
               end
            endcase
         end
         // insert: walk the table downward, shifting starts behind the cursor
         S_INS_RD: begin
            line_raddr = idx_ff[LA-1:0];
            state_in   = S_INS_WR;
         end
         S_INS_WR: begin
            if (line_q > from_ff) begin
               line_wr.en   = 1'b1;
               line_wr.addr = idx_ff[LA-1:0] + LA'(is_nl);
               line_wr.data = line_q + 1'b1;
               if (idx_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_INS_RD;
               end
            end else begin
               if (is_nl) begin
                  line_wr.en   = 1'b1;
                  line_wr.addr = idx_ff[LA-1:0] + 1'b1;
                  line_wr.data = from_ff + 1'b1;
                  lines_in     = lines_ff + 1'b1;
               end
               state_in = S_DONE;
            end
         end
         // delete: compact the table in place, dropping starts inside the range
         S_DEL_RD: begin
            if (idx_ff == lines_ff) begin
               lines_in = (wr_ff == '0) ? CW'(1) : wr_ff;
               state_in = (kind_ff == gtb_pkg::KIND_DEL_RNG) ? S_MOVE : S_DONE;
            end else begin
               line_raddr = idx_ff[LA-1:0];
               state_in   = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            if (!(line_q > from_ff && line_q <= to_ff)) begin
               line_wr.en   = 1'b1;
               line_wr.addr = wr_ff[LA-1:0];
               line_wr.data = (line_q > to_ff) ? line_q - del : line_q;
               wr_in        = wr_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_DEL_RD;
         end
         // gap move, one byte at a time: read it, then write it across the gap
         S_MOVE: begin
            if (target_ff < gl_ff) begin
               text_raddr = TA'(gl_ff - 1'b1);
               state_in   = S_MV_LWR;
            end else if (target_ff > gl_ff) begin
               text_raddr = gh_ff[TA-1:0];
               state_in   = S_MV_RWR;
            end else begin
               if (kind_ff == gtb_pkg::KIND_DEL_RNG) begin
                  gh_in = gh_ff + del;
               end
               state_in = S_DONE;
            end
         end
         S_MV_LWR: begin
            text_wr.en   = 1'b1;
            text_wr.addr = TA'(gh_ff - 1'b1);
            text_wr.data = text_q;
            gl_in        = gl_ff - 1'b1;
            gh_in        = gh_ff - 1'b1;
            state_in     = S_MOVE;
         end
         S_MV_RWR: begin
            text_wr.en   = 1'b1;
            text_wr.addr = gl_ff[TA-1:0];
            text_wr.data = text_q;
            gl_in        = gl_ff + 1'b1;
            gh_in        = gh_ff + 1'b1;
            state_in     = S_MOVE;
         end
         S_RD_WAIT: begin
            rd_in    = text_q;
            state_in = S_DONE;
         end
         // binary search for the last start at or before the position
         S_BS_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in     = mid_sum[LA:1];
               line_raddr = mid_in;
               state_in   = S_BS_CMP;
            end else begin
               lnum_in  = best_ff;
               loff_in  = bval_ff;
               col_in   = pos_ff - bval_ff;
               state_in = S_DONE;
            end
         end
         S_BS_CMP: begin
            if (line_q <= pos_ff) begin
               best_in = mid_ff;
               bval_in = line_q;
               lo_in   = CW'(mid_ff) + 1'b1;
            end else begin
               hi_in = CW'(mid_ff);
            end
            state_in = S_BS_RD;
         end
         S_OFF_WAIT: begin
            loff_in  = line_q;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, lines_ff, gl_ff, len, loff_ff, col_ff, lnum_ff,
                               rd_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      lzero_in = (line_raddr == '0);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gl_ff        <= '0;
         gh_ff        <= PW'(gtb_pkg::TEXT_CAPACITY);
         lines_ff     <= CW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gl_ff        <= gl_in;
         gh_ff        <= gh_in;
         lines_ff     <= lines_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      pos_ff      <= pos_in;
      pend_ff     <= pend_in;
      lidx_ff     <= lidx_in;
      idx_ff      <= idx_in;
      wr_ff       <= wr_in;
      from_ff     <= from_in;
      to_ff       <= to_in;
      target_ff   <= target_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      best_ff     <= best_in;
      bval_ff     <= bval_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      lnum_ff     <= lnum_in;
      col_ff      <= col_in;
      loff_ff     <= loff_in;
      rsp_data_ff <= rsp_data_in;
      lzero_ff    <= lzero_in;
   end

endmodule

/* hdl/gtb_text_ram.sv */
module gtb_text_ram (
   input  logic                        clock,
   input  gtb_pkg::text_wr_type        wr,
   input  logic [gtb_pkg::TEXT_AW-1:0] rd_addr,
   output logic [7:0]                  rd_data
);

   logic [7:0] mem [gtb_pkg::TEXT_CAPACITY];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hdl/gtb_line_ram.sv */
module gtb_line_ram (
   input  logic                        clock,
   input  gtb_pkg::line_wr_type        wr,
   input  logic [gtb_pkg::LINE_AW-1:0] rd_addr,
   output logic [gtb_pkg::POS_W-1:0]   rd_data
);

   logic [gtb_pkg::POS_W-1:0] mem [gtb_pkg::MAX_LINES];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
